/* hdl/mdpa_pkg.sv */
// Package for the modular dot-product accumulate core.
// Holds shared constants, register-file and job types and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mdpa_pkg;

   // Widths fixed by the operand and register formats.
   localparam int OPERAND_W  = 31;
   localparam int INVERSE_W  = 32;
   localparam int SUM_W      = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Register reset values.
   localparam logic [OPERAND_W-1:0] MODULUS_RESET     = 31'd2147483647;
   localparam logic [INVERSE_W-1:0] INVERSE_RESET     = 32'd2147483649;
   localparam logic [OPERAND_W-1:0] POW32_MOD_RESET   = 31'd2;
   localparam logic [OPERAND_W-1:0] POW64_MOD_RESET   = 31'd4;

   // Default queue depths.
   localparam int JOB_QUEUE_DEPTH    = 4;
   localparam int RESULT_QUEUE_DEPTH = 4;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODULUS   = 2'd0,
      CSR_INVERSE   = 2'd1,
      CSR_POW32_MOD = 2'd2,
      CSR_POW64_MOD = 2'd3
   } csr_index_type;

   // Configuration register file.
   typedef struct packed {
      logic [OPERAND_W-1:0] modulus;
      logic [INVERSE_W-1:0] barrett_inverse;
      logic [OPERAND_W-1:0] two_pow_32_mod;
      logic [OPERAND_W-1:0] two_pow_64_mod;
   } cfg_type;

   // One finished dot product handed from the accumulator to the reducer.
   typedef struct packed {
      logic [SUM_W-1:0]     high_sum;
      logic [SUM_W-1:0]     low_sum;
      logic [OPERAND_W-1:0] prior_value;
   } job_type;

endpackage : mdpa_pkg

`default_nettype wire

/* hdl/mdpa_fifo.sv */
// Small first-in first-out queue built from registers.
// Used between the accumulator and the reducer and on the result side.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module mdpa_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty,
   output logic                  full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and fill-count update with wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule : mdpa_fifo

`default_nettype wire

/* hdl/mdpa_front.sv */
// Front end: accepts element pairs, multiplies them and keeps the two exact
// running sums; on the last term it hands a finished job to the reducer queue.
// Depends on mdpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mdpa_front #(
   parameter int QUEUE_DEPTH = mdpa_pkg::JOB_QUEUE_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   output logic                                   req_full,
   input  wire logic [mdpa_pkg::OPERAND_W-1:0]    req_a_value,
   input  wire logic [mdpa_pkg::OPERAND_W-1:0]    req_b_value,
   input  wire logic [mdpa_pkg::OPERAND_W-1:0]    req_prior_value,
   input  wire logic                              req_last_term,
   output logic                                   job_push,
   output mdpa_pkg::job_type                      job_data,
   input  wire logic                              job_pop
);

   localparam int CRED_W = $clog2(QUEUE_DEPTH + 1);
   localparam int PROD_W = 2 * mdpa_pkg::OPERAND_W;

   logic                             accept;
   logic [CRED_W-1:0]                credit_ff, credit_in;

   logic                             s1_valid_ff;
   logic [mdpa_pkg::OPERAND_W-1:0]   s1_a_ff, s1_b_ff, s1_prior_ff;
   logic                             s1_last_ff;

   logic                             s2_valid_ff;
   logic [PROD_W-1:0]                s2_prod_ff;
   logic [mdpa_pkg::OPERAND_W-1:0]   s2_prior_ff;
   logic                             s2_last_ff;

   logic [mdpa_pkg::SUM_W-1:0]       high_sum_ff, high_sum_in;
   logic [mdpa_pkg::SUM_W-1:0]       low_sum_ff, low_sum_in;
   logic [mdpa_pkg::SUM_W-1:0]       high_next;
   logic [mdpa_pkg::SUM_W-1:0]       low_next;

   // Each accepted last term reserves a queue slot in advance.
   assign req_full = (credit_ff == '0);
   assign accept   = req_push && !req_full;

   always_comb begin
      credit_in = credit_ff;
      if ((accept && req_last_term) && !job_pop) begin
         credit_in = credit_ff - 1'b1;
      end else if (!(accept && req_last_term) && job_pop) begin
         credit_in = credit_ff + 1'b1;
      end
   end

   // Sums after adding the product in the last stage.
   assign high_next = high_sum_ff + mdpa_pkg::SUM_W'(s2_prod_ff[PROD_W-1:32]);
   assign low_next  = low_sum_ff + mdpa_pkg::SUM_W'(s2_prod_ff[31:0]);

   always_comb begin
      high_sum_in = high_sum_ff;
      low_sum_in  = low_sum_ff;
      if (s2_valid_ff) begin
         high_sum_in = s2_last_ff ? '0 : high_next;
         low_sum_in  = s2_last_ff ? '0 : low_next;
      end
   end

   assign job_push             = s2_valid_ff && s2_last_ff;
   assign job_data.high_sum    = high_next;
   assign job_data.low_sum     = low_next;
   assign job_data.prior_value = s2_prior_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff   <= CRED_W'(QUEUE_DEPTH);
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         high_sum_ff <= '0;
         low_sum_ff  <= '0;
      end else begin
         credit_ff   <= credit_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         high_sum_ff <= high_sum_in;
         low_sum_ff  <= low_sum_in;
      end
   end

   // Operand capture and product stage.
   always_ff @(posedge clock) begin
      s1_a_ff     <= req_a_value;
      s1_b_ff     <= req_b_value;
      s1_prior_ff <= req_prior_value;
      s1_last_ff  <= req_last_term;
      s2_prod_ff  <= PROD_W'(s1_a_ff) * PROD_W'(s1_b_ff);
      s2_prior_ff <= s1_prior_ff;
      s2_last_ff  <= s1_last_ff;
   end

endmodule : mdpa_front

`default_nettype wire

/* hdl/mdpa_reduce.sv */
// Back end: folds one finished job modulo the prime with five Barrett steps
// run one after another on a shared multi-cycle reduction datapath.
// Depends on mdpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mdpa_reduce (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire mdpa_pkg::cfg_type                 cfg,
   input  wire logic                              job_empty,
   input  wire mdpa_pkg::job_type                 job_data,
   output logic                                   job_pop,
   input  wire logic                              res_full,
   output logic                                   res_push,
   output logic [mdpa_pkg::OPERAND_W-1:0]         res_data
);

   // Reduction datapath states, one-hot.
   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_LOAD = 9'b000000010,
      ST_XB   = 9'b000000100,
      ST_Q    = 9'b000001000,
      ST_QM   = 9'b000010000,
      ST_SUM  = 9'b000100000,
      ST_SUB  = 9'b001000000,
      ST_FIX1 = 9'b010000000,
      ST_FIX2 = 9'b100000000
   } state_type;

   // The five Barrett steps of one fold.
   typedef enum logic [2:0] {
      OP_HIGH  = 3'd0,
      OP_POW64 = 3'd1,
      OP_MID   = 3'd2,
      OP_POW32 = 3'd3,
      OP_FINAL = 3'd4
   } op_type;

   state_type       state_ff, state_in;
   op_type          op_ff, op_in;

   logic [63:0]     job_high_ff, job_low_ff;
   logic [30:0]     job_prior_ff;
   logic [31:0]     tmp_ff, t64_ff, t32_ff;

   logic [63:0]     n_ff, n_in;
   logic [63:0]     xb_ff;
   logic [1:0]      xh_ff;
   logic [34:0]     q_ff;
   logic [62:0]     qlm_ff;
   logic [33:0]     qhm_ff;
   logic [63:0]     qm_ff;
   logic [63:0]     r_ff;
   logic [63:0]     mod64;
   logic [63:0]     r_fix;
   logic [62:0]     pow_prod;
   logic [33:0]     x_val;
   logic            step_done;

   assign mod64 = 64'(cfg.modulus);
   assign x_val = n_ff[63:30];
   assign r_fix = (r_ff >= mod64) ? (r_ff - mod64) : r_ff;

   assign job_pop   = (state_ff == ST_IDLE) && !job_empty && !res_full;
   assign step_done = (state_ff == ST_FIX2);
   assign res_push  = step_done && (op_ff == OP_FINAL);
   assign res_data  = r_fix[30:0];

   // Step operand: multiply by a power-of-two residue where the step needs it.
   always_comb begin
      pow_prod = '0;
      n_in     = '0;
      case (op_ff)
         OP_HIGH: begin
            n_in = 64'(job_high_ff[63:32]);
         end
         OP_POW64: begin
            pow_prod = 63'(tmp_ff) * 63'(cfg.two_pow_64_mod);
            n_in     = 64'(pow_prod);
         end
         OP_MID: begin
            n_in = 64'(job_high_ff[31:0]) + 64'(job_low_ff[63:32]);
         end
         OP_POW32: begin
            pow_prod = 63'(tmp_ff) * 63'(cfg.two_pow_32_mod);
            n_in     = 64'(pow_prod);
         end
         OP_FINAL: begin
            n_in = 64'(t64_ff) + 64'(t32_ff) + 64'(job_low_ff[31:0]) + 64'(job_prior_ff);
         end
         default: begin
            n_in = '0;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_pop) begin
               state_in = ST_LOAD;
               op_in    = OP_HIGH;
            end
         end
         ST_LOAD: state_in = ST_XB;
         ST_XB:   state_in = ST_Q;
         ST_Q:    state_in = ST_QM;
         ST_QM:   state_in = ST_SUM;
         ST_SUM:  state_in = ST_SUB;
         ST_SUB:  state_in = ST_FIX1;
         ST_FIX1: state_in = ST_FIX2;
         ST_FIX2: begin
            if (op_ff == OP_FINAL) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_LOAD;
               op_in    = op_type'(op_ff + 3'd1);
            end
         end
         default: begin
            state_in = ST_IDLE;
            op_in    = OP_HIGH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_HIGH;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   // Barrett datapath: each state loads its own result registers.
   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_high_ff  <= job_data.high_sum;
         job_low_ff   <= job_data.low_sum;
         job_prior_ff <= job_data.prior_value;
      end
      if (state_ff == ST_LOAD) begin
         n_ff <= n_in;
      end
      if (state_ff == ST_XB) begin
         xb_ff <= 64'(x_val[31:0]) * 64'(cfg.barrett_inverse);
         xh_ff <= x_val[33:32];
      end
      if (state_ff == ST_Q) begin
         q_ff <= (35'(xh_ff) * 35'(cfg.barrett_inverse)) + 35'(xb_ff[63:32]);
      end
      if (state_ff == ST_QM) begin
         qlm_ff <= 63'(q_ff[31:0]) * 63'(cfg.modulus);
         qhm_ff <= 34'(q_ff[34:32]) * 34'(cfg.modulus);
      end
      if (state_ff == ST_SUM) begin
         qm_ff <= 64'(qlm_ff) + {qhm_ff[31:0], 32'b0};
      end
      if (state_ff == ST_SUB) begin
         r_ff <= n_ff - qm_ff;
      end
      if (state_ff == ST_FIX1) begin
         r_ff <= r_fix;
      end
      if (step_done) begin
         case (op_ff)
            OP_HIGH:  tmp_ff <= r_fix[31:0];
            OP_POW64: t64_ff <= r_fix[31:0];
            OP_MID:   tmp_ff <= r_fix[31:0];
            OP_POW32: t32_ff <= r_fix[31:0];
            default: begin
            end
         endcase
      end
   end

endmodule : mdpa_reduce

`default_nettype wire

/* hdl/modular_dot_product_accumulate_core.sv */
// Modular dot-product accumulate core: multiplies streamed element pairs,
// accumulates exactly, and on each last term emits (prior + dot) mod p.
// Channels: req_ is a queue input (push/full), rsp_ a queue output
// (empty/pop, the oldest result sits on rsp_sum_mod while rsp_empty is low),
// csr_ a valid/ready register write port that is always ready.
// Term items enter at one per cycle while req_full is low; the multiply and
// accumulate pipeline registers the operands, the product and the sums.
// A last-term item hands its sums to a job queue; the reduction unit takes
// the job in IDLE, then runs five Barrett steps on it, each through LOAD,
// XB, Q, QM, SUM, SUB, FIX1 and FIX2. It starts no new job before the last
// is finished, so it sets the sustained rate of results; between last terms
// the front keeps taking terms until the job queue is reserved out, then
// raises req_full. When rsp_pop stays low, results collect in the result
// queue and the reducer waits for a free slot before starting the next job.
// Reset clears both sums, the queues and the registers to their reset values.
// Registers are to be written only while idle, but nothing enforces this.
// Depends on mdpa_pkg, mdpa_fifo, mdpa_front and mdpa_reduce.
`timescale 1ns / 1ps
`default_nettype none

module modular_dot_product_accumulate_core #(
   parameter int JOB_DEPTH    = mdpa_pkg::JOB_QUEUE_DEPTH,
   parameter int RESULT_DEPTH = mdpa_pkg::RESULT_QUEUE_DEPTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_push,
   output logic                                    req_full,
   input  wire logic [mdpa_pkg::OPERAND_W-1:0]     req_a_value,
   input  wire logic [mdpa_pkg::OPERAND_W-1:0]     req_b_value,
   input  wire logic [mdpa_pkg::OPERAND_W-1:0]     req_prior_value,
   input  wire logic                               req_last_term,
   output logic                                    rsp_empty,
   input  wire logic                               rsp_pop,
   output logic [mdpa_pkg::OPERAND_W-1:0]          rsp_sum_mod,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [mdpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mdpa_pkg::CSR_DATA_W-1:0]    csr_data
);

   mdpa_pkg::cfg_type              cfg_ff, cfg_in;
   logic                           job_push;
   mdpa_pkg::job_type              job_in_data;
   logic                           job_pop;
   mdpa_pkg::job_type              job_out_data;
   logic                           job_empty;
   logic                           res_push;
   logic [mdpa_pkg::OPERAND_W-1:0] res_data;
   logic                           res_full;

   // Register writes; the port never stalls.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (mdpa_pkg::csr_index_type'(csr_index))
            mdpa_pkg::CSR_MODULUS:   cfg_in.modulus         = csr_data[30:0];
            mdpa_pkg::CSR_INVERSE:   cfg_in.barrett_inverse = csr_data;
            mdpa_pkg::CSR_POW32_MOD: cfg_in.two_pow_32_mod  = csr_data[30:0];
            mdpa_pkg::CSR_POW64_MOD: cfg_in.two_pow_64_mod  = csr_data[30:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.modulus         <= mdpa_pkg::MODULUS_RESET;
         cfg_ff.barrett_inverse <= mdpa_pkg::INVERSE_RESET;
         cfg_ff.two_pow_32_mod  <= mdpa_pkg::POW32_MOD_RESET;
         cfg_ff.two_pow_64_mod  <= mdpa_pkg::POW64_MOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Accumulator front end.
   mdpa_front #(
      .QUEUE_DEPTH (JOB_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_a_value     (req_a_value),
      .req_b_value     (req_b_value),
      .req_prior_value (req_prior_value),
      .req_last_term   (req_last_term),
      .job_push        (job_push),
      .job_data        (job_in_data),
      .job_pop         (job_pop)
   );

   // Job queue between the accumulator and the reducer.
   mdpa_fifo #(
      .WIDTH ($bits(mdpa_pkg::job_type)),
      .DEPTH (JOB_DEPTH)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .pop       (job_pop),
      .pop_data  (job_out_data),
      .empty     (job_empty),
      .full      ()
   );

   // Barrett reduction back end.
   mdpa_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_empty (job_empty),
      .job_data  (job_out_data),
      .job_pop   (job_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res_data  (res_data)
   );

   // Result queue toward the consumer.
   mdpa_fifo #(
      .WIDTH (mdpa_pkg::OPERAND_W),
      .DEPTH (RESULT_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .pop       (rsp_pop),
      .pop_data  (rsp_sum_mod),
      .empty     (rsp_empty),
      .full      (res_full)
   );

endmodule : modular_dot_product_accumulate_core

`default_nettype wire

/* dv/tb_modular_dot_product_accumulate_core.sv */
// Self-checking testbench for the modular dot-product accumulate core.
// Streams element pairs through the queue-style ports, predicts every residue
// with an exact Barrett model, and checks results in order. Depends on mdpa_pkg.
`timescale 1ns / 1ps

module tb_modular_dot_product_accumulate_core;

   localparam int CYCLE_LIMIT     = 1_200_000;
   localparam int DRAIN_CYCLES    = 64;
   localparam int TERMS_PER_PHASE = 230;
   localparam logic [mdpa_pkg::OPERAND_W-1:0] ALL_ONES = 31'h7FFFFFFF;

   // Expected-residue store with its own copy of the registers and the sums.
   class dot_product_board;
      logic [mdpa_pkg::OPERAND_W-1:0] modulus;
      logic [mdpa_pkg::INVERSE_W-1:0] inverse;
      logic [mdpa_pkg::OPERAND_W-1:0] pow32_mod;
      logic [mdpa_pkg::OPERAND_W-1:0] pow64_mod;
      logic [mdpa_pkg::SUM_W-1:0]     high_sum;
      logic [mdpa_pkg::SUM_W-1:0]     low_sum;
      logic [mdpa_pkg::OPERAND_W-1:0] expected_sums[$];
      int                             dot_products;

      function new();
         modulus      = mdpa_pkg::MODULUS_RESET;
         inverse      = mdpa_pkg::INVERSE_RESET;
         pow32_mod    = mdpa_pkg::POW32_MOD_RESET;
         pow64_mod    = mdpa_pkg::POW64_MOD_RESET;
         high_sum     = '0;
         low_sum      = '0;
         dot_products = 0;
      endfunction

      function void set_register(input mdpa_pkg::csr_index_type idx,
                                 input logic [mdpa_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            mdpa_pkg::CSR_MODULUS:   modulus   = data[mdpa_pkg::OPERAND_W-1:0];
            mdpa_pkg::CSR_INVERSE:   inverse   = data;
            mdpa_pkg::CSR_POW32_MOD: pow32_mod = data[mdpa_pkg::OPERAND_W-1:0];
            mdpa_pkg::CSR_POW64_MOD: pow64_mod = data[mdpa_pkg::OPERAND_W-1:0];
            default: ;
         endcase
      endfunction

      // One Barrett step on a 64-bit value, with up to two corrective subtractions.
      function logic [63:0] barrett_step(input logic [63:0] n);
         logic [63:0] x;
         logic [63:0] q;
         logic [63:0] m;
         logic [63:0] r;
         x = n >> 30;
         m = {33'd0, modulus};
         q = {62'd0, x[33:32]} * {32'd0, inverse}
           + (({32'd0, x[31:0]} * {32'd0, inverse}) >> 32);
         r = n - q * m;
         if (r >= m) r = r - m;
         if (r >= m) r = r - m;
         return {32'd0, r[31:0]};
      endfunction

      // Accumulate one accepted term; a last term folds the sums into a residue.
      function void note_term(input logic [mdpa_pkg::OPERAND_W-1:0] a,
                              input logic [mdpa_pkg::OPERAND_W-1:0] b,
                              input logic [mdpa_pkg::OPERAND_W-1:0] prior, input logic last);
         logic [63:0] product;
         logic [63:0] fold64;
         logic [63:0] fold32;
         logic [63:0] total;
         product  = {33'd0, a} * {33'd0, b};
         high_sum = high_sum + {32'd0, product[63:32]};
         low_sum  = low_sum + {32'd0, product[31:0]};
         if (last) begin
            fold64 = barrett_step(barrett_step({32'd0, high_sum[63:32]}) * {33'd0, pow64_mod});
            fold32 = barrett_step(barrett_step({32'd0, high_sum[31:0]} + {32'd0, low_sum[63:32]})
                                  * {33'd0, pow32_mod});
            total  = barrett_step(fold64 + fold32 + {32'd0, low_sum[31:0]} + {33'd0, prior});
            expected_sums.push_back(total[mdpa_pkg::OPERAND_W-1:0]);
            high_sum = '0;
            low_sum  = '0;
         end
      endfunction

      // Compare a popped residue with the oldest one waiting.
      function bit check_sum(input logic [mdpa_pkg::OPERAND_W-1:0] got,
                             output logic [mdpa_pkg::OPERAND_W-1:0] want);
         want = expected_sums.pop_front();
         dot_products++;
         return got === want;
      endfunction

      function int pending();
         return expected_sums.size();
      endfunction
   endclass

   logic                            clock;
   logic                            reset           = 1'b1;
   logic                            req_push        = 1'b0;
   logic                            req_full;
   logic [mdpa_pkg::OPERAND_W-1:0]  req_a_value     = '0;
   logic [mdpa_pkg::OPERAND_W-1:0]  req_b_value     = '0;
   logic [mdpa_pkg::OPERAND_W-1:0]  req_prior_value = '0;
   logic                            req_last_term   = 1'b0;
   logic                            rsp_empty;
   logic                            rsp_pop         = 1'b0;
   logic [mdpa_pkg::OPERAND_W-1:0]  rsp_sum_mod;
   logic                            csr_valid       = 1'b0;
   logic                            csr_ready;
   logic [mdpa_pkg::CSR_IDX_W-1:0]  csr_index       = '0;
   logic [mdpa_pkg::CSR_DATA_W-1:0] csr_data        = '0;

   dot_product_board               board;
   int                             mismatches   = 0;
   int                             cycle_count  = 0;
   int                             terms_sent   = 0;
   int                             settings_run = 1;
   bit                             push_steady  = 1'b0;
   bit                             pop_steady   = 1'b0;
   logic [mdpa_pkg::OPERAND_W-1:0] current_modulus = mdpa_pkg::MODULUS_RESET;
   logic [mdpa_pkg::OPERAND_W-1:0] want_sum;

   modular_dot_product_accumulate_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_a_value     (req_a_value),
      .req_b_value     (req_b_value),
      .req_prior_value (req_prior_value),
      .req_last_term   (req_last_term),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_sum_mod     (rsp_sum_mod),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d residues outstanding.",
                  cycle_count, board.pending());
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      if (mismatches < 40) $display("[cycle %0d] mismatch: %s", cycle_count, what);
      mismatches++;
   endtask

   // Accepted beats on the input and register channels update the prediction.
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready === 1'b1)
         board.set_register(mdpa_pkg::csr_index_type'(csr_index), csr_data);
      if (!reset && req_push && req_full === 1'b0)
         board.note_term(req_a_value, req_b_value, req_prior_value, req_last_term);
   end

   // Every popped residue is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_pop && rsp_empty === 1'b0) begin
         if (board.pending() == 0)
            report_mismatch($sformatf("residue %0d with no dot product waiting", rsp_sum_mod));
         else if (!board.check_sum(rsp_sum_mod, want_sum))
            report_mismatch($sformatf("sum_mod got %0d expected %0d", rsp_sum_mod, want_sum));
      end
   end

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Result side: pop in runs, at times stalling between them.
   initial begin : pop_driver
      int stall;
      @(posedge clock);
      forever begin
         rsp_pop <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         if ($urandom_range(0, 15) == 0) pop_steady = !pop_steady;
         stall = pop_steady ? 0 : pick_gap();
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Drive one term beat and hold it until accepted, then maybe idle.
   task automatic push_term(input logic [mdpa_pkg::OPERAND_W-1:0] a,
                            input logic [mdpa_pkg::OPERAND_W-1:0] b,
                            input logic [mdpa_pkg::OPERAND_W-1:0] prior, input logic last);
      int gap;
      req_push        <= 1'b1;
      req_a_value     <= a;
      req_b_value     <= b;
      req_prior_value <= prior;
      req_last_term   <= last;
      do @(posedge clock); while (req_full !== 1'b0);
      terms_sent++;
      if ($urandom_range(0, 63) == 0) push_steady = !push_steady;
      gap = push_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off the sender until every expected residue has been popped.
   task automatic pause_until_drained();
      if (board.pending() != 0) begin
         req_push <= 1'b0;
         while (board.pending() != 0) @(posedge clock);
      end
   endtask

   // Drain and let the reducer go quiet, so registers can be written.
   task automatic settle_idle();
      req_push <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input mdpa_pkg::csr_index_type idx,
                                 input logic [mdpa_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
   endtask

   task automatic write_settings(input logic [mdpa_pkg::OPERAND_W-1:0] p,
                                 input logic [mdpa_pkg::INVERSE_W-1:0] inv,
                                 input logic [mdpa_pkg::OPERAND_W-1:0] p32,
                                 input logic [mdpa_pkg::OPERAND_W-1:0] p64);
      write_register(mdpa_pkg::CSR_MODULUS, {1'b0, p});
      write_register(mdpa_pkg::CSR_INVERSE, inv);
      write_register(mdpa_pkg::CSR_POW32_MOD, {1'b0, p32});
      write_register(mdpa_pkg::CSR_POW64_MOD, {1'b0, p64});
      csr_valid <= 1'b0;
      @(posedge clock);
      current_modulus = p;
      settings_run++;
   endtask

   // Program a modulus together with its matching Barrett constants.
   task automatic program_modulus(input logic [mdpa_pkg::OPERAND_W-1:0] p);
      logic [127:0] wide_p;
      logic [127:0] inv;
      logic [127:0] p32;
      logic [127:0] p64;
      wide_p = {97'd0, p};
      inv    = (128'd1 << 62) / wide_p;
      p32    = (128'd1 << 32) % wide_p;
      p64    = (128'd1 << 64) % wide_p;
      write_settings(p, inv[31:0], p32[30:0], p64[30:0]);
   endtask

   // Operands lean toward zero, all ones and the top residue.
   function automatic logic [mdpa_pkg::OPERAND_W-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return ALL_ONES;
         2: return (current_modulus != 0) ? current_modulus - 1'b1 : ALL_ONES;
         3: return 31'($urandom_range(0, 15));
         default: return 31'($urandom());
      endcase
   endfunction

   // Dot-product lengths: mostly short, some medium, a rare long one.
   function automatic int pick_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return $urandom_range(1, 3);
      if (roll < 85) return $urandom_range(4, 10);
      if (roll < 98) return $urandom_range(11, 40);
      return $urandom_range(100, 300);
   endfunction

   task automatic run_random_terms(input int count);
      int sent;
      int len;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 39) == 0) pause_until_drained();
         len = pick_length();
         for (int i = 0; i < len; i++)
            push_term(pick_operand(), pick_operand(), pick_operand(), i == len - 1);
         sent += len;
      end
   endtask

   initial begin : stimulus
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed terms under the reset registers: zero, operands at or above the
      // modulus, the top residue, a wrapping prior and a run that fills the high limb.
      push_term('0, '0, '0, 1'b1);
      push_term(ALL_ONES, ALL_ONES, ALL_ONES, 1'b1);
      push_term(ALL_ONES - 1'b1, ALL_ONES - 1'b1, ALL_ONES - 1'b1, 1'b1);
      push_term(31'd1, 31'd1, ALL_ONES - 1'b1, 1'b1);
      for (int i = 0; i < 8; i++)
         push_term(ALL_ONES, ALL_ONES, 31'($urandom()), i == 7);
      push_term(31'h40000000, 31'd2, ALL_ONES, 1'b0);
      push_term('0, '0, 31'h55555555, 1'b1);
      run_random_terms(TERMS_PER_PHASE);
      settle_idle();

      // Smallest modulus in range, which gives the largest Barrett constant.
      program_modulus(31'd1073741825);
      run_random_terms(TERMS_PER_PHASE);
      settle_idle();

      // Two random odd moduli with consistent constants.
      repeat (2) begin
         program_modulus(31'($urandom_range(32'h40000001, 32'h7FFFFFFF) | 1));
         run_random_terms(TERMS_PER_PHASE);
         settle_idle();
      end

      // Constants that do not match the modulus.
      write_settings(31'($urandom_range(32'h40000001, 32'h7FFFFFFF)), $urandom(),
                     31'($urandom()), 31'($urandom()));
      run_random_terms(TERMS_PER_PHASE);
      settle_idle();

      // Zero modulus with every other register at an extreme.
      write_settings('0, 32'hFFFFFFFF, ALL_ONES, '0);
      run_random_terms(TERMS_PER_PHASE);
      settle_idle();

      // Largest modulus, written explicitly this time.
      program_modulus(ALL_ONES);
      run_random_terms(TERMS_PER_PHASE);
      settle_idle();

      $display("Run covered %0d terms and %0d dot products over %0d register settings,",
               terms_sent, board.dot_products, settings_run);
      $display("with random gaps and stalls on both channels; %0d mismatches.", mismatches);
      if (mismatches == 0 && board.pending() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
